[src/kps_pkg.sv]
`default_nettype none

package kps_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MATRIX_W = 16;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned COL_W   = 2;
  localparam int unsigned KEYMAP_W = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]  scan_row;
    logic              release_wait;
    logic [CODE_W-1:0] prev_key;
    logic [TIME_W-1:0] prev_time;
  } kps_state_t;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
    logic              awaiting_release;
  } kps_result_t;

endpackage

`default_nettype wire

[src/kps_in_if.sv]
`default_nettype none

interface kps_in_if;
  import kps_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [MATRIX_W-1:0] pressed_matrix;

  modport source (output valid, output now_ms, output pressed_matrix, input ready);
  modport sink   (input valid, input now_ms, input pressed_matrix, output ready);
endinterface

`default_nettype wire

[src/kps_out_if.sv]
`default_nettype none

interface kps_out_if;
  import kps_pkg::*;

  logic              valid;
  logic              ready;
  logic              key_valid;
  logic [CODE_W-1:0] key_code;
  logic              awaiting_release;

  modport source (output valid, output key_valid, output key_code,
                  output awaiting_release, input ready);
  modport sink   (input valid, input key_valid, input key_code,
                  input awaiting_release, output ready);
endinterface

`default_nettype wire

[src/kps_step.sv]
`default_nettype none

module kps_step
  import kps_pkg::*;
(
  input  var kps_state_t              state_cur,
  input  var logic [TIME_W-1:0]       now_ms,
  input  var logic [MATRIX_W-1:0]     pressed_matrix,
  input  var logic [2*KEYMAP_W-1:0]   keymap,
  input  var logic [TIME_W-1:0]       debounce_time,
  output kps_state_t                  state_nxt,
  output kps_result_t                 result
);

  logic [3:0]            row_cols;
  logic [COL_W-1:0]      col;
  logic [ROW_W+COL_W-1:0] key_idx;
  logic [CODE_W-1:0]     key_code;
  logic [TIME_W-1:0]     elapsed;
  logic                  report;

  assign row_cols = pressed_matrix[{state_cur.scan_row, 2'b00} +: 4];

  // Lowest pressed column wins.
  always_comb begin
    if (row_cols[0]) begin
      col = 2'd0;
    end else if (row_cols[1]) begin
      col = 2'd1;
    end else if (row_cols[2]) begin
      col = 2'd2;
    end else begin
      col = 2'd3;
    end
  end

  assign key_idx  = {state_cur.scan_row, col};
  assign key_code = keymap[{key_idx, 3'b000} +: CODE_W];
  assign elapsed  = now_ms - state_cur.prev_time;

  assign report = !state_cur.release_wait && (row_cols != 4'd0) &&
                  ((elapsed >= debounce_time) || (key_code != state_cur.prev_key));

  always_comb begin
    state_nxt = state_cur;
    if (state_cur.release_wait) begin
      if (pressed_matrix == '0) begin
        state_nxt.release_wait = 1'b0;
      end
    end else if (report) begin
      state_nxt.prev_key     = key_code;
      state_nxt.prev_time    = now_ms;
      state_nxt.release_wait = 1'b1;
    end else begin
      state_nxt.scan_row = state_cur.scan_row + 2'd1;
    end
  end

  assign result.key_valid        = report;
  assign result.key_code         = report ? key_code : '0;
  assign result.awaiting_release = state_nxt.release_wait;

endmodule

`default_nettype wire

[src/matrix_keypad_scanner_unit.sv]
`default_nettype none

// 4x4 key matrix scanner.
// Requests arrive on in_ch (valid/ready): each carries the current time in
// milliseconds and the sampled 16-bit pressed-key matrix. Every request yields
// exactly one result on out_ch: key_valid, key_code (zero when no key is
// reported) and awaiting_release, the release-wait flag after the update.
// The key table and debounce time are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while no request is in flight,
// which the block itself does not enforce; index 3 is ignored. An accepted
// request is held in the input register, evaluated by kps_step and registered
// in the result register, which drives out_ch. One request is accepted per
// cycle unless out_ch stalls, a rate set by the scan state's loop through
// compare and table select. When the receiver stalls, the result register
// holds its value, the input register keeps one more request, and in_ch.ready
// drops once both are full. Reset (rst_n low, synchronous) empties both
// registers, sets the scan row and release wait to zero, clears the previous
// key and its time, clears the key table and sets the debounce time to 50 ms.
module matrix_keypad_scanner_unit
  import kps_pkg::*;
(
  input  var logic                  clk,
  input  var logic                  rst_n,
  kps_in_if.sink                    in_ch,
  kps_out_if.source                 out_ch,
  input  var logic                  cfg_we,
  input  var logic [CFG_IDX_W-1:0]  cfg_index,
  input  var logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [KEYMAP_W-1:0] keymap_low_r;
  logic [KEYMAP_W-1:0] keymap_high_r;
  logic [TIME_W-1:0]   debounce_r;

  // Input register.
  logic                in_v_r;
  logic [TIME_W-1:0]   now_r;
  logic [MATRIX_W-1:0] matrix_r;

  // Scan state and result register.
  kps_state_t  state_r;
  kps_state_t  state_nxt;
  kps_result_t result_nxt;
  kps_result_t result_r;
  logic        out_v_r;

  logic advance;
  logic take_in;

  // The evaluated request moves into the result register when that register
  // is empty or is being drained this cycle.
  assign advance = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign take_in = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keymap_low_r  <= '0;
      keymap_high_r <= '0;
      debounce_r    <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEYMAP_LOW:  keymap_low_r  <= cfg_wdata;
        CFG_KEYMAP_HIGH: keymap_high_r <= cfg_wdata;
        CFG_DEBOUNCE:    debounce_r    <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  kps_step u_step (
    .state_cur      (state_r),
    .now_ms         (now_r),
    .pressed_matrix (matrix_r),
    .keymap         ({keymap_high_r, keymap_low_r}),
    .debounce_time  (debounce_r),
    .state_nxt      (state_nxt),
    .result         (result_nxt)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_in) begin
      now_r    <= in_ch.now_ms;
      matrix_r <= in_ch.pressed_matrix;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.key_valid        = result_r.key_valid;
  assign out_ch.key_code         = result_r.key_code;
  assign out_ch.awaiting_release = result_r.awaiting_release;

`ifndef SYNTHESIS
  // A reported key always starts release waiting.
  a_report_waits : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && result_r.key_valid) |-> result_r.awaiting_release)
    else $error("reported key without release wait");

  // The code is zero whenever no key is reported.
  a_code_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !result_r.key_valid) |-> (result_r.key_code == '0))
    else $error("nonzero code without a report");

  // Scan state only changes when a request is evaluated.
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!advance) |=> $stable(state_r))
    else $error("scan state changed without a request");

  // A report records its code as the previous key.
  a_prev_key : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result_nxt.key_valid) |=> (state_r.prev_key == result_r.key_code))
    else $error("previous key not updated on report");
`endif

endmodule

`default_nettype wire
